// ----- sv/hed_pkg.sv -----
package hed_pkg;

  // front queue depth between classifier and decode engine
  localparam int FIFO_DEPTH = 4;

  // longest entity name held after the ampersand
  localparam int NAME_MAX = 6;
  localparam int LEN_W    = $clog2(NAME_MAX + 1);
  localparam int NI_W     = $clog2(NAME_MAX);

  // replay buffer: held name bytes, the ending byte and what was still queued
  localparam int RQ_DEPTH = NAME_MAX + 2;

  // character codes
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // one classified text byte
  typedef struct packed {
    logic [7:0] data;
    logic       is_amp;
    logic       is_semi;
    logic       is_digit;
  } tok_t;

  // one queue entry between front and back
  typedef struct packed {
    tok_t tok;
    logic last;
  } q_item_t;

  // name matcher control from the engine
  typedef struct packed {
    logic             clear;
    logic             push;
    logic [LEN_W-1:0] pos;
    tok_t             tok;
  } match_cmd_t;

  // named entity: name right-aligned in nm, first char at the highest used byte
  typedef struct packed {
    logic [47:0]      nm;
    logic [LEN_W-1:0] len;
    logic [7:0]       val;
  } ent_t;

  localparam int ENT_COUNT = 100;

  localparam ent_t ENT_TABLE [ENT_COUNT] = '{
    '{48'("Auml"), 3'd4, 8'd196},   '{48'("AElig"), 3'd5, 8'd198},
    '{48'("Acirc"), 3'd5, 8'd194},  '{48'("Aring"), 3'd5, 8'd197},
    '{48'("Aacute"), 3'd6, 8'd193}, '{48'("Agrave"), 3'd6, 8'd192},
    '{48'("Atilde"), 3'd6, 8'd195}, '{48'("Ccedil"), 3'd6, 8'd199},
    '{48'("ETH"), 3'd3, 8'd208},    '{48'("Euml"), 3'd4, 8'd203},
    '{48'("Ecirc"), 3'd5, 8'd202},  '{48'("Eacute"), 3'd6, 8'd201},
    '{48'("Egrave"), 3'd6, 8'd200}, '{48'("Iuml"), 3'd4, 8'd207},
    '{48'("Icirc"), 3'd5, 8'd206},  '{48'("Iacute"), 3'd6, 8'd205},
    '{48'("Igrave"), 3'd6, 8'd204}, '{48'("Ntilde"), 3'd6, 8'd209},
    '{48'("Ouml"), 3'd4, 8'd214},   '{48'("Ocirc"), 3'd5, 8'd212},
    '{48'("Oacute"), 3'd6, 8'd211}, '{48'("Ograve"), 3'd6, 8'd210},
    '{48'("Oslash"), 3'd6, 8'd216}, '{48'("Otilde"), 3'd6, 8'd213},
    '{48'("THORN"), 3'd5, 8'd222},  '{48'("Uuml"), 3'd4, 8'd220},
    '{48'("Ucirc"), 3'd5, 8'd219},  '{48'("Uacute"), 3'd6, 8'd218},
    '{48'("Ugrave"), 3'd6, 8'd217}, '{48'("Yacute"), 3'd6, 8'd221},
    '{48'("amp"), 3'd3, 8'd38},     '{48'("auml"), 3'd4, 8'd228},
    '{48'("acirc"), 3'd5, 8'd226},  '{48'("acute"), 3'd5, 8'd180},
    '{48'("aelig"), 3'd5, 8'd230},  '{48'("aring"), 3'd5, 8'd229},
    '{48'("aacute"), 3'd6, 8'd225}, '{48'("agrave"), 3'd6, 8'd224},
    '{48'("atilde"), 3'd6, 8'd227}, '{48'("brvbar"), 3'd6, 8'd166},
    '{48'("cent"), 3'd4, 8'd162},   '{48'("copy"), 3'd4, 8'd169},
    '{48'("cedil"), 3'd5, 8'd184},  '{48'("ccedil"), 3'd6, 8'd231},
    '{48'("curren"), 3'd6, 8'd164}, '{48'("deg"), 3'd3, 8'd176},
    '{48'("divide"), 3'd6, 8'd247}, '{48'("eth"), 3'd3, 8'd240},
    '{48'("euml"), 3'd4, 8'd235},   '{48'("ecirc"), 3'd5, 8'd234},
    '{48'("eacute"), 3'd6, 8'd233}, '{48'("egrave"), 3'd6, 8'd232},
    '{48'("frac12"), 3'd6, 8'd189}, '{48'("frac14"), 3'd6, 8'd188},
    '{48'("frac34"), 3'd6, 8'd190}, '{48'("gt"), 3'd2, 8'd62},
    '{48'("iuml"), 3'd4, 8'd239},   '{48'("icirc"), 3'd5, 8'd238},
    '{48'("iexcl"), 3'd5, 8'd161},  '{48'("iacute"), 3'd6, 8'd237},
    '{48'("igrave"), 3'd6, 8'd236}, '{48'("iquest"), 3'd6, 8'd191},
    '{48'("lt"), 3'd2, 8'd60},      '{48'("laquo"), 3'd5, 8'd171},
    '{48'("macr"), 3'd4, 8'd175},   '{48'("micro"), 3'd5, 8'd181},
    '{48'("middot"), 3'd6, 8'd183}, '{48'("not"), 3'd3, 8'd172},
    '{48'("nbsp"), 3'd4, 8'd32},    '{48'("ntilde"), 3'd6, 8'd241},
    '{48'("ordf"), 3'd4, 8'd170},   '{48'("ordm"), 3'd4, 8'd186},
    '{48'("ouml"), 3'd4, 8'd246},   '{48'("ocirc"), 3'd5, 8'd244},
    '{48'("oacute"), 3'd6, 8'd243}, '{48'("ograve"), 3'd6, 8'd242},
    '{48'("oslash"), 3'd6, 8'd248}, '{48'("otilde"), 3'd6, 8'd245},
    '{48'("para"), 3'd4, 8'd182},   '{48'("pound"), 3'd5, 8'd163},
    '{48'("plusmn"), 3'd6, 8'd177}, '{48'("quot"), 3'd4, 8'd34},
    '{48'("reg"), 3'd3, 8'd174},    '{48'("raquo"), 3'd5, 8'd187},
    '{48'("shy"), 3'd3, 8'd173},    '{48'("sect"), 3'd4, 8'd167},
    '{48'("sup1"), 3'd4, 8'd185},   '{48'("sup2"), 3'd4, 8'd178},
    '{48'("sup3"), 3'd4, 8'd179},   '{48'("szlig"), 3'd5, 8'd223},
    '{48'("thorn"), 3'd5, 8'd254},  '{48'("times"), 3'd5, 8'd215},
    '{48'("uml"), 3'd3, 8'd168},    '{48'("uuml"), 3'd4, 8'd252},
    '{48'("ucirc"), 3'd5, 8'd251},  '{48'("uacute"), 3'd6, 8'd250},
    '{48'("ugrave"), 3'd6, 8'd249}, '{48'("yen"), 3'd3, 8'd165},
    '{48'("yuml"), 3'd4, 8'd255},   '{48'("yacute"), 3'd6, 8'd253}
  };

endpackage

// ----- sv/hed_front.sv -----
module hed_front #(
  parameter int DEPTH = hed_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             q_valid,
  output hed_pkg::q_item_t q_item,
  input  logic             q_pop
);
  import hed_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  q_item_t         beat;
  logic            push;
  logic            pop;

  // classify the incoming byte
  always_comb begin
    beat.tok.data     = in_byte;
    beat.tok.is_amp   = (in_byte == CH_AMP);
    beat.tok.is_semi  = (in_byte == CH_SEMI);
    beat.tok.is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    beat.last         = in_last;
  end

  // queue flags
  assign in_ready = (count != CW'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= beat;
    end
  end

endmodule

// ----- sv/hed_match.sv -----
module hed_match (
  input  logic                      clk,
  input  hed_pkg::match_cmd_t       cmd,
  input  logic [hed_pkg::LEN_W-1:0] len,
  output logic                      ok,
  output logic [7:0]                val
);
  import hed_pkg::*;

  logic [ENT_COUNT-1:0] mask;
  logic [ENT_COUNT-1:0] step_hit;
  logic [ENT_COUNT-1:0] sel;
  logic                 tab_hit;
  logic [7:0]           tab_val;
  logic                 num_first;
  logic                 num_ok;
  logic [7:0]           num_acc;

  // per entry: does the pushed byte match the entry's char at this position
  for (genvar i = 0; i < ENT_COUNT; i++) begin : g_ent
    localparam int LEN_I = int'(ENT_TABLE[i].len);
    logic [NAME_MAX-1:0] ph;
    for (genvar k = 0; k < NAME_MAX; k++) begin : g_pos
      if (k < LEN_I) begin : g_cmp
        assign ph[k] = (cmd.pos == LEN_W'(k)) &&
                       (cmd.tok.data == ENT_TABLE[i].nm[8*(LEN_I-1-k) +: 8]);
      end else begin : g_none
        assign ph[k] = 1'b0;
      end
    end
    assign step_hit[i] = |ph;
    assign sel[i]      = mask[i] && (len == ENT_TABLE[i].len);
  end

  // candidate mask narrows one name byte at a time
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mask <= '1;
    end else if (cmd.push) begin
      mask <= mask & step_hit;
    end
  end

  // numeric form, decimal value kept mod 256
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      num_first <= 1'b0;
    end else if (cmd.push) begin
      if (cmd.pos == '0) begin
        num_first <= (cmd.tok.data == CH_HASH);
        num_ok    <= 1'b1;
        num_acc   <= '0;
      end else begin
        num_ok  <= num_ok && cmd.tok.is_digit;
        num_acc <= 8'((num_acc << 3) + (num_acc << 1) + {4'b0, cmd.tok.data[3:0]});
      end
    end
  end

  // table result, names are unique so at most one entry selects
  always_comb begin
    tab_val = '0;
    for (int i = 0; i < ENT_COUNT; i++) begin
      if (sel[i]) begin
        tab_val = tab_val | ENT_TABLE[i].val;
      end
    end
    tab_hit = |sel;
  end

  assign ok  = num_first ? (num_ok && (len >= LEN_W'(2)) && (len <= LEN_W'(4))) : tab_hit;
  assign val = num_first ? num_acc : tab_val;

endmodule

// ----- sv/hed_back.sv -----
module hed_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  hed_pkg::q_item_t          q_item,
  output logic                      q_pop,
  output hed_pkg::match_cmd_t       m_cmd,
  output logic [hed_pkg::LEN_W-1:0] m_len,
  input  logic                      m_ok,
  input  logic [7:0]                m_val,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      run_end,
  output logic                      stream_end
);
  import hed_pkg::*;

  localparam int RQ_IW = $clog2(RQ_DEPTH);
  localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

  // entity state
  logic             pending;
  logic [LEN_W-1:0] name_len;
  tok_t             name_tok [NAME_MAX];

  // replay buffer, head at entry zero
  tok_t             rq [RQ_DEPTH];
  logic [RQ_CW-1:0] rq_cnt;

  // step in progress
  logic             step_act;
  logic             step_last;

  // last emitted byte, held until we know whether it closes the step
  logic             hold_valid;
  logic [7:0]       hold_byte;
  logic             hold_fin;
  logic             hold_sfin;

  // next-state logic
  logic             out_can;
  logic             hold_free;
  logic             use_rq;
  logic             flush;
  logic             act;
  tok_t             cur_tok;
  logic             cur_last;
  tok_t             rq_shift [RQ_DEPTH];
  logic [RQ_CW-1:0] rem_cnt;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             fail;
  logic             name_wr;
  logic             pending_next;
  logic [LEN_W-1:0] name_len_next;
  tok_t             rq_next [RQ_DEPTH];
  logic [RQ_CW-1:0] rq_cnt_next;
  logic             step_end;
  logic             emit_go;
  logic             out_load;

  // pick a byte and work out what it does
  always_comb begin
    out_can   = !out_valid || out_ready;
    hold_free = !hold_valid || out_can;
    use_rq    = (rq_cnt != '0);
    flush     = step_act && !use_rq;
    act       = hold_free && (step_act || q_valid);
    cur_tok   = use_rq ? rq[0] : q_item.tok;
    cur_last  = step_act ? step_last : q_item.last;
    q_pop     = act && !step_act;

    for (int i = 0; i < RQ_DEPTH - 1; i++) begin
      rq_shift[i] = rq[RQ_IW'(i + 1)];
    end
    rq_shift[RQ_DEPTH-1] = '0;
    rem_cnt = use_rq ? RQ_CW'(rq_cnt - 1'b1) : '0;

    emit          = 1'b0;
    emit_byte     = cur_tok.data;
    fail          = 1'b0;
    name_wr       = 1'b0;
    pending_next  = pending;
    name_len_next = name_len;
    rq_next       = rq_shift;
    rq_cnt_next   = rem_cnt;
    m_cmd         = '0;
    m_cmd.pos     = name_len;
    m_cmd.tok     = cur_tok;

    if (flush) begin
      // end of stream with an entity open: literal '&' then replay the name
      emit          = 1'b1;
      emit_byte     = CH_AMP;
      pending_next  = 1'b0;
      name_len_next = '0;
      for (int k = 0; k < NAME_MAX; k++) begin
        if (k < int'(name_len)) begin
          rq_next[k] = name_tok[NI_W'(k)];
        end
      end
      rq_cnt_next = RQ_CW'(name_len);
    end else if (!pending) begin
      if (cur_tok.is_amp) begin
        pending_next  = 1'b1;
        name_len_next = '0;
        m_cmd.clear   = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end else if (cur_tok.is_semi) begin
      if (m_ok) begin
        emit          = 1'b1;
        emit_byte     = m_val;
        pending_next  = 1'b0;
        name_len_next = '0;
      end else begin
        fail = 1'b1;
      end
    end else if (name_len < LEN_W'(NAME_MAX)) begin
      name_wr       = 1'b1;
      m_cmd.push    = 1'b1;
      name_len_next = name_len + 1'b1;
    end else begin
      fail = 1'b1;
    end

    // failed entity: '&', then name bytes, ending byte and the rest replayed
    if (fail) begin
      emit          = 1'b1;
      emit_byte     = CH_AMP;
      pending_next  = 1'b0;
      name_len_next = '0;
      for (int i = 0; i < RQ_DEPTH; i++) begin
        if (i > int'(name_len)) begin
          rq_next[i] = rq_shift[RQ_IW'(i - int'(name_len) - 1)];
        end else if (i == int'(name_len)) begin
          rq_next[i] = cur_tok;
        end
      end
      for (int k = 0; k < NAME_MAX; k++) begin
        if (k < int'(name_len)) begin
          rq_next[k] = name_tok[NI_W'(k)];
        end
      end
      rq_cnt_next = RQ_CW'(int'(name_len) + 1 + int'(rem_cnt));
    end

    if (!act) begin
      m_cmd.clear = 1'b0;
      m_cmd.push  = 1'b0;
    end

    step_end = (rq_cnt_next == '0) && !(cur_last && pending_next);
    emit_go  = act && emit;
    out_load = out_can && hold_valid && (hold_fin || emit_go);
  end

  assign m_len = name_len;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      name_len   <= '0;
      rq_cnt     <= '0;
      step_act   <= 1'b0;
      step_last  <= 1'b0;
      hold_valid <= 1'b0;
      hold_fin   <= 1'b0;
      hold_sfin  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (act) begin
        pending   <= pending_next;
        name_len  <= name_len_next;
        rq_cnt    <= rq_cnt_next;
        step_act  <= !step_end;
        step_last <= cur_last;
      end

      // hold stage
      if (emit_go) begin
        hold_valid <= 1'b1;
        hold_fin   <= step_end;
        hold_sfin  <= step_end && cur_last;
      end else if (act && step_end && hold_valid && !hold_fin) begin
        hold_fin  <= 1'b1;
        hold_sfin <= cur_last;
      end else if (out_load) begin
        hold_valid <= 1'b0;
      end

      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (act && name_wr) begin
      name_tok[NI_W'(name_len)] <= cur_tok;
    end
    if (act) begin
      for (int i = 0; i < RQ_DEPTH; i++) begin
        rq[i] <= rq_next[i];
      end
    end
    if (emit_go) begin
      hold_byte <= emit_byte;
    end
    if (out_load) begin
      out_byte   <= hold_byte;
      run_end    <= hold_fin;
      stream_end <= hold_sfin;
    end
  end

endmodule

// ----- sv/html_entity_decoder_core.sv -----
// HTML character-entity decoder, one text byte per input beat.
// Input channel: in_byte/in_last with in_valid/in_ready. in_last marks the
// final byte of a stream; any entity still open is then given up and its
// held bytes are replayed through the engine after a literal '&'.
// Output channel: out_byte/run_end/stream_end with out_valid/out_ready.
// Each input beat gives zero or more output beats; run_end marks the last
// one caused by that input, stream_end the last one of the stream.
// Path: an accepted beat waits in the front queue until the engine takes it;
// its result passes through the staging register and then the output register;
// a result that is not the last of its run waits in the staging register
// until the next result of that run is ready.
// Throughput: one beat per cycle for plain text and good entities while
// input is waiting and the output is not stalled. A failed entity replays
// its held name bytes and the ending byte through the engine, one per cycle
// when not stalled; a stream end with an entity open first emits a literal
// '&' and then replays the held name bytes the same way.
// A front queue of FIFO_DEPTH beats keeps accepting input while the engine
// or the receiver stalls; a stalled receiver holds the output register and
// one staged result, then the engine and later the queue fill and in_ready
// drops. Reset empties the queue and closes any open entity.
module html_entity_decoder_core #(
  parameter int FIFO_DEPTH = hed_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       stream_end
);
  import hed_pkg::*;

  logic             q_valid;
  q_item_t          q_item;
  logic             q_pop;
  match_cmd_t       m_cmd;
  logic [LEN_W-1:0] m_len;
  logic             m_ok;
  logic [7:0]       m_val;

  // front: classify and queue
  hed_front #(
    .DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // entity name matcher
  hed_match u_match (
    .clk (clk),
    .cmd (m_cmd),
    .len (m_len),
    .ok  (m_ok),
    .val (m_val)
  );

  // back: decode engine and output stage
  hed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .m_cmd      (m_cmd),
    .m_len      (m_len),
    .m_ok       (m_ok),
    .m_val      (m_val),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .stream_end (stream_end)
  );

  // engine never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // matcher is either restarted or fed, never both
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(m_cmd.clear && m_cmd.push))
    else $error("matcher clear and push together");

  // stream end only closes a run
  a_stream_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_end) |-> run_end)
    else $error("stream_end without run_end");

  // nothing offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import hed_pkg::*;

  localparam int ENT_N      = 100;
  localparam int MAX_BEATS  = 8;
  localparam int STIM_ITEMS = 255;
  localparam int QUIET_TAIL = 40;

  // one input beat waiting in the driver queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_beat_t;

  // one decoded output beat
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } dec_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       stream_end;

  text_beat_t stim_q[$];
  dec_beat_t  decoded_q[$];
  int         err_count = 0;

  // decoder state as the testbench tracks it
  logic        ent_open = 1'b0;
  int unsigned held_len = 0;
  logic [7:0]  held [7];

  // idling control for both sides
  int feed_tick = 0;
  int feed_pct  = 0;
  int feed_gap  = 0;
  int sink_tick = 0;
  int sink_pct  = 0;
  int sink_gap  = 0;

  // latin-1 named entities and their byte values
  string ent_name [ENT_N] = '{
    "Auml", "AElig", "Acirc", "Aring", "Aacute", "Agrave", "Atilde", "Ccedil", "ETH", "Euml",
    "Ecirc", "Eacute", "Egrave", "Iuml", "Icirc", "Iacute", "Igrave", "Ntilde", "Ouml", "Ocirc",
    "Oacute", "Ograve", "Oslash", "Otilde", "THORN", "Uuml", "Ucirc", "Uacute", "Ugrave",
    "Yacute",
    "amp", "auml", "acirc", "acute", "aelig", "aring", "aacute", "agrave", "atilde", "brvbar",
    "cent", "copy", "cedil", "ccedil", "curren", "deg", "divide", "eth", "euml", "ecirc",
    "eacute", "egrave", "frac12", "frac14", "frac34", "gt", "iuml", "icirc", "iexcl", "iacute",
    "igrave", "iquest", "lt", "laquo", "macr", "micro", "middot", "not", "nbsp", "ntilde",
    "ordf", "ordm", "ouml", "ocirc", "oacute", "ograve", "oslash", "otilde", "para", "pound",
    "plusmn", "quot", "reg", "raquo", "shy", "sect", "sup1", "sup2", "sup3", "szlig",
    "thorn", "times", "uml", "uuml", "ucirc", "uacute", "ugrave", "yen", "yuml", "yacute"
  };
  logic [7:0] ent_val [ENT_N] = '{
    196, 198, 194, 197, 193, 192, 195, 199, 208, 203,
    202, 201, 200, 207, 206, 205, 204, 209, 214, 212,
    211, 210, 216, 213, 222, 220, 219, 218, 217, 221,
    38, 228, 226, 180, 230, 229, 225, 224, 227, 166,
    162, 169, 184, 231, 164, 176, 247, 240, 235, 234,
    233, 232, 189, 188, 190, 62, 239, 238, 161, 237,
    236, 191, 60, 171, 175, 181, 183, 172, 32, 241,
    170, 186, 246, 244, 243, 242, 248, 245, 182, 163,
    177, 34, 174, 187, 173, 167, 185, 178, 179, 223,
    254, 215, 168, 252, 251, 250, 249, 165, 255, 253
  };

  html_entity_decoder_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .stream_end (stream_end)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // reset at the start of the run only
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 100)
      $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // resolve the held name: numeric form or a named entity
  function automatic bit resolve_name(output logic [7:0] value);
    int acc;
    bit hit;
    value = 8'h00;
    if (held_len == 0 || held_len > NAME_MAX) return 1'b0;
    if (held[0] == CH_HASH) begin
      if (held_len < 2 || held_len > 4) return 1'b0;
      acc = 0;
      for (int i = 1; i < held_len; i++) begin
        if (held[i] < CH_ZERO || held[i] > CH_NINE) return 1'b0;
        acc = acc * 10 + int'(held[i] - CH_ZERO);
      end
      value = acc[7:0];
      return 1'b1;
    end
    for (int k = 0; k < ENT_N; k++) begin
      if (ent_name[k].len() == held_len) begin
        hit = 1'b1;
        for (int i = 0; i < held_len; i++)
          if (ent_name[k][i] != held[i]) hit = 1'b0;
        if (hit) begin
          value = ent_val[k];
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // run one input byte through the decoder state, queue the decoded beats
  task automatic decode_byte(input logic [7:0] byte_in, input logic last_in);
    logic [7:0] pend[$];
    logic [7:0] rescan[$];
    logic [7:0] res[$];
    logic [7:0] b;
    logic [7:0] value;
    bit         fail;
    pend.push_back(byte_in);
    forever begin
      while (pend.size() > 0) begin
        b = pend.pop_front();
        fail = 1'b0;
        if (!ent_open) begin
          if (b == CH_AMP) begin
            ent_open = 1'b1;
            held_len = 0;
          end else if (res.size() < MAX_BEATS) begin
            res.push_back(b);
          end
        end else if (b == CH_SEMI) begin
          if (resolve_name(value)) begin
            if (res.size() < MAX_BEATS) res.push_back(value);
            ent_open = 1'b0;
            held_len = 0;
          end else begin
            fail = 1'b1;
          end
        end else if (held_len < NAME_MAX) begin
          held[held_len] = b;
          held_len++;
        end else begin
          fail = 1'b1;
        end
        // failed entity: literal ampersand, then replay held bytes and the ender
        if (fail) begin
          if (res.size() < MAX_BEATS) res.push_back(CH_AMP);
          rescan = {};
          for (int i = 0; i < held_len; i++) rescan.push_back(held[i]);
          rescan.push_back(b);
          while (pend.size() > 0) rescan.push_back(pend.pop_front());
          pend = rescan;
          ent_open = 1'b0;
          held_len = 0;
        end
      end
      // end of stream with an entity open: give it up and flush
      if (last_in && ent_open) begin
        if (res.size() < MAX_BEATS) res.push_back(CH_AMP);
        for (int i = 0; i < held_len; i++) pend.push_back(held[i]);
        ent_open = 1'b0;
        held_len = 0;
      end else begin
        break;
      end
    end
    foreach (res[k])
      decoded_q.push_back('{res[k], k == res.size() - 1, (k == res.size() - 1) && last_in});
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(8'h61, 8'h7a));
    return 8'($urandom_range(8'h41, 8'h5a));
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last);
    stim_q.push_back('{data, last});
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic mark_last();
    stim_q[stim_q.size() - 1].last = 1'b1;
  endtask

  // driver: present queued beats, hold each until taken
  always @(posedge clk) begin : feed
    feed_tick++;
    if (feed_tick % 64 == 0) feed_pct = pick_idle_pct();
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) void'(stim_q.pop_front());
      if (feed_gap > 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (stim_q.size() > QUIET_TAIL && $urandom_range(0, 99) < feed_pct) begin
        feed_gap = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        in_valid <= 1'b1;
        in_byte  <= stim_q[0].data;
        in_last  <= stim_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on input beats, check output beats, drive out_ready
  always @(posedge clk) begin : check
    dec_beat_t want;
    sink_tick++;
    if (sink_tick % 64 == 32) sink_pct = pick_idle_pct();
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte, in_last);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output beat %02h", out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (run_end !== want.run_end)
            report_mismatch($sformatf("run_end %b, want %b (byte %02h)",
                                      run_end, want.run_end, want.data));
          if (stream_end !== want.stream_end)
            report_mismatch($sformatf("stream_end %b, want %b (byte %02h)",
                                      stream_end, want.stream_end, want.data));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (stim_q.size() > QUIET_TAIL && $urandom_range(0, 99) < sink_pct) begin
        sink_gap = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int k;
    int n;
    // directed: byte extremes, empty name, ampersand inside a name,
    // numeric wrap, overlong name with a full rescan, stream end mid-entity
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_str("&;");
    push_str("&a&lt;");
    push_str("&#300;");
    push_str("&frac12x");
    mark_last();
    push_str("&#9");
    mark_last();

    // random text: raw bytes, well-formed entities, broken ones and noise
    while (stim_q.size() < STIM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        3, 4, 5: begin
          k = $urandom_range(0, ENT_N - 1);
          push_str({"&", ent_name[k], ";"});
        end
        6: begin
          push_byte(CH_AMP, 1'b0);
          push_byte(CH_HASH, 1'b0);
          repeat ($urandom_range(1, 3)) push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
          push_byte(CH_SEMI, 1'b0);
        end
        7: begin
          push_byte(CH_AMP, 1'b0);
          repeat ($urandom_range(1, 6)) push_byte(rand_letter(), 1'b0);
          push_byte(CH_SEMI, 1'b0);
        end
        8: begin
          case ($urandom_range(0, 3))
            0: push_str("&;");
            1: begin
              // name runs past six bytes
              push_byte(CH_AMP, 1'b0);
              repeat ($urandom_range(7, 8)) push_byte(rand_letter(), 1'b0);
              if ($urandom_range(0, 1) == 1) push_byte(CH_SEMI, 1'b0);
            end
            2: begin
              // numeric form with no digits, too many, or a letter
              push_byte(CH_AMP, 1'b0);
              push_byte(CH_HASH, 1'b0);
              n = $urandom_range(0, 2);
              if (n == 1) repeat (4) push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
              if (n == 2) begin
                push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
                push_byte(rand_letter(), 1'b0);
              end
              push_byte(CH_SEMI, 1'b0);
            end
            default: begin
              // entity left open, often at the end of a stream
              push_byte(CH_AMP, 1'b0);
              repeat ($urandom_range(0, 5)) push_byte(rand_letter(), 1'b0);
              if ($urandom_range(0, 1) == 1) mark_last();
            end
          endcase
        end
        default: begin
          // noise made of the interesting characters
          repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
              0: push_byte(CH_AMP, 1'b0);
              1: push_byte(CH_SEMI, 1'b0);
              2: push_byte(CH_HASH, 1'b0);
              3: push_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
              4: push_byte(rand_letter(), 1'b0);
              default: push_byte(8'($urandom_range(0, 255)), 1'b0);
            endcase
          end
        end
      endcase
      if ($urandom_range(0, 11) == 0) mark_last();
    end
    mark_last();

    // wait for every beat to be taken and every result to arrive
    while (rst) @(posedge clk);
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    for (n = 0; n < 5000 && decoded_q.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", decoded_q.size()));
    if (err_count == 0) begin
      $display("** html_entity_decoder_core: PASSED **");
    end else begin
      $display("** html_entity_decoder_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("** html_entity_decoder_core: FAILED **");
    $finish;
  end

endmodule
